>>> hw/rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: tempo knob smoother shared definitions
// Item types, fixed tempo range constants, exponential map constants and the
// sequencer state type.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int TEMPO_MIN     = 30;
  localparam int TEMPO_MAX     = 300;
  localparam int TEMPO_DEFAULT = 120;
  localparam int KNOB_BITS     = 12;

  localparam int CODE_W    = 12;
  localparam int TEMPO_W   = 17;
  localparam int PERIOD_W  = 21;
  localparam int FRAC_BITS = 24;
  localparam int ROOT_W    = 31;
  localparam int LOG_W     = 29;
  localparam int EI_W      = 4;
  localparam int EI_MAX    = 12;
  localparam int CNT_W     = $clog2(FRAC_BITS);
  localparam int SCALE_W   = TEMPO_W + ROOT_W;

  typedef struct packed {
    logic [CODE_W-1:0] knob_code;
  } knob_item_t;

  typedef struct packed {
    logic [TEMPO_W-1:0]  tempo_q8;
    logic [PERIOD_W-1:0] period_us;
  } tempo_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SCALE,
    ST_SHIFT,
    ST_ACCUM,
    ST_MEAN,
    ST_DIVSET,
    ST_DIV,
    ST_DONE
  } tks_state_t;

  typedef logic [FRAC_BITS-1:0][ROOT_W-1:0] root_tab_t;

  function automatic int log2_int();
    int n;
    n = 0;
    for (int k = 0; k < 16; k++) begin
      if (n == k && ((64'(TEMPO_MIN) << (k + 1)) <= 64'(TEMPO_MAX))) begin
        n = k + 1;
      end
    end
    return n;
  endfunction

  localparam int LOG_INT = log2_int();
  localparam logic [63:0] MANT0 = (64'(TEMPO_MAX) << 30) / (64'(TEMPO_MIN) << LOG_INT);

  function automatic logic [FRAC_BITS-1:0] log2_frac(input logic [63:0] m0);
    logic [63:0]          m;
    logic [FRAC_BITS-1:0] fr;
    m  = m0;
    fr = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m  = (m * m) >> 30;
      fr = {fr[FRAC_BITS-2:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        fr[0] = 1'b1;
        m     = m >> 1;
      end
    end
    return fr;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] x0);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    x   = x0;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t root_table();
    logic [63:0] c;
    root_tab_t   tab;
    c = 64'd1 << 31;
    for (int i = 0; i < FRAC_BITS; i++) begin
      c      = isqrt(c << 30);
      tab[i] = ROOT_W'(c);
    end
    return tab;
  endfunction

  localparam logic [LOG_W-1:0] LOG_RATIO =
    LOG_W'((64'(LOG_INT) << FRAC_BITS) | 64'(log2_frac(MANT0)));
  localparam root_tab_t ROOT_Q30 = root_table();

  localparam logic [TEMPO_W-1:0] BASE_Q8    = TEMPO_W'(TEMPO_MIN * 256);
  localparam logic [TEMPO_W-1:0] LIMIT_Q8   = TEMPO_W'(TEMPO_MAX * 256);
  localparam logic [TEMPO_W-1:0] DEFAULT_Q8 = TEMPO_W'(TEMPO_DEFAULT * 256);
  localparam logic               MAP_FLAT   = (TEMPO_MAX <= TEMPO_MIN);
  localparam int                 CODE_TOP   = (1 << KNOB_BITS) - 1;

  localparam logic [63:0]         PERIOD_NUM = 64'd15360000000;
  localparam logic [TEMPO_W-1:0]  NUM_HI     = TEMPO_W'(PERIOD_NUM >> PERIOD_W);
  localparam logic [PERIOD_W-1:0] NUM_LO     = PERIOD_W'(PERIOD_NUM);

endpackage

>>> hw/rtl/tks_stream_if.sv
// ----------------------------------------------------------------------------
// tks_stream_if: valid/ready stream channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface tks_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/tempo_knob_smoother.sv
// ----------------------------------------------------------------------------
// tempo_knob_smoother: exponential knob to tempo map with boxcar smoothing
// Takes one knob code per transaction on knob and returns the smoothed tempo
// (Q8 beats per minute) and the note period in microseconds on tempo.
//
// Usage:
//   knob  (sink)  : knob_code, one ADC sample per transaction
//   tempo (source): tempo_q8 and period_us, one transaction per sample
// Sequence: each sample runs the 24-step root product of the exponential map
//   (one multiply per cycle), the scale, shift, accumulate and mean steps
//   and the 21-step bit-serial period divider, which is skipped when the
//   period saturates. A sample is finished before the next one is taken,
//   which happens once the result has moved to the output register.
// Reset: the window is filled with the default tempo and the sum matches it;
//   the sequencer returns to idle and the output register is emptied.
// Stall: a finished result waits in the output register; the next sample is
//   still taken and processed, and it waits in its last step until the
//   output register is free.
// ----------------------------------------------------------------------------
module tempo_knob_smoother
  import tks_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic            clk,
  input  logic            rst,
  tks_stream_if.sink      knob,
  tks_stream_if.source    tempo
);

  localparam int WIN_LOG    = $clog2(WINDOW);
  localparam int SUM_W      = TEMPO_W + WIN_LOG;
  localparam int MEAN_SHIFT = SUM_W + WIN_LOG;
  localparam int RECIP_W    = SUM_W + 1;
  localparam int MPROD_W    = SUM_W + RECIP_W;
  localparam int EPROD_W    = LOG_W + CODE_W;
  localparam int SHIFT_W    = SCALE_W + EI_MAX;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW * TEMPO_DEFAULT * 256);

  tks_state_t state, state_next;

  logic [CNT_W-1:0]    cnt;
  logic                out_valid;
  tempo_item_t         out_item;

  logic [FRAC_BITS-1:0] frac_sr;
  logic [EI_W-1:0]      ei;
  logic [ROOT_W-1:0]    p;
  logic [SCALE_W-1:0]   scaled;
  logic [TEMPO_W-1:0]   fresh;
  logic [TEMPO_W-1:0]   win [WINDOW];
  logic [SUM_W-1:0]     sum;
  logic [MPROD_W-1:0]   mean_prod;
  logic [TEMPO_W-1:0]   tempo_res;
  logic [TEMPO_W-1:0]   rem;
  logic [PERIOD_W-1:0]  q_sr;

  logic                 accept;
  logic                 load_out;
  logic [CODE_W-1:0]    code_sat;
  logic [EPROD_W-1:0]   expo_prod;
  logic [LOG_W-1:0]     expo;
  logic [LOG_W-FRAC_BITS-1:0] ei_raw;
  logic [2*ROOT_W-1:0]  root_prod;
  logic [SHIFT_W-1:0]   shifted;
  logic [SHIFT_W-1:0]   mapped;
  logic [TEMPO_W-1:0]   tempo_val;
  logic [TEMPO_W:0]     trial;

  // knob code to log-domain exponent
  assign code_sat  = (32'(knob.data.knob_code) > CODE_TOP) ? CODE_W'(CODE_TOP)
                                                           : knob.data.knob_code;
  assign expo_prod = EPROD_W'(LOG_RATIO) * EPROD_W'(code_sat);
  assign expo      = LOG_W'(expo_prod >> KNOB_BITS);
  assign ei_raw    = expo[LOG_W-1:FRAC_BITS];

  assign root_prod = (2*ROOT_W)'(p) * (2*ROOT_W)'(ROOT_Q30[cnt]);
  assign shifted   = (SHIFT_W'(scaled) << ei) >> 30;
  assign mapped    = (shifted > SHIFT_W'(LIMIT_Q8)) ? SHIFT_W'(LIMIT_Q8) : shifted;
  assign tempo_val = TEMPO_W'(mean_prod >> MEAN_SHIFT);
  assign trial     = {rem, q_sr[PERIOD_W-1]};

  assign accept    = knob.valid && knob.ready;
  assign tempo.valid = out_valid;
  assign tempo.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    knob.ready = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        knob.ready = 1'b1;
        if (knob.valid) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:  state_next = ST_SHIFT;
      ST_SHIFT:  state_next = ST_ACCUM;
      ST_ACCUM:  state_next = ST_MEAN;
      ST_MEAN:   state_next = ST_DIVSET;
      ST_DIVSET: begin
        if (tempo_val <= NUM_HI) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == CNT_W'(PERIOD_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || tempo.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and smoothing state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
      sum       <= SUM_RESET;
      for (int i = 0; i < WINDOW; i++) begin
        win[i] <= DEFAULT_Q8;
      end
    end else begin
      case (state)
        ST_IDLE:   cnt <= '0;
        ST_ROOT:   cnt <= cnt + 1'b1;
        ST_DIVSET: cnt <= '0;
        ST_DIV:    cnt <= cnt + 1'b1;
        ST_ACCUM: begin
          win[0] <= fresh;
          for (int i = 1; i < WINDOW; i++) begin
            win[i] <= win[i-1];
          end
          sum <= sum - SUM_W'(win[WINDOW-1]) + SUM_W'(fresh);
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (tempo.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      frac_sr <= expo[FRAC_BITS-1:0];
      ei      <= (ei_raw > (LOG_W-FRAC_BITS)'(EI_MAX)) ? EI_W'(EI_MAX) : EI_W'(ei_raw);
      p       <= ROOT_W'(64'd1 << 30);
    end
    case (state)
      ST_ROOT: begin
        frac_sr <= {frac_sr[FRAC_BITS-2:0], 1'b0};
        if (frac_sr[FRAC_BITS-1]) begin
          p <= ROOT_W'(root_prod >> 30);
        end
      end
      ST_SCALE: scaled <= SCALE_W'(BASE_Q8) * SCALE_W'(p);
      ST_SHIFT: fresh  <= MAP_FLAT ? BASE_Q8 : TEMPO_W'(mapped);
      ST_MEAN:  mean_prod <= MPROD_W'(sum) * MPROD_W'(RECIP);
      ST_DIVSET: begin
        tempo_res <= tempo_val;
        rem       <= NUM_HI;
        if (tempo_val <= NUM_HI) begin
          q_sr <= '1;
        end else begin
          q_sr <= NUM_LO;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, tempo_res}) begin
          rem  <= TEMPO_W'(trial - {1'b0, tempo_res});
          q_sr <= {q_sr[PERIOD_W-2:0], 1'b1};
        end else begin
          rem  <= TEMPO_W'(trial);
          q_sr <= {q_sr[PERIOD_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_item.tempo_q8  <= tempo_res;
      out_item.period_us <= q_sr;
    end
  end

endmodule

>>> sim/tempo_knob_smoother_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tempo_knob_smoother_test: self-checking bench for the tempo knob smoother
// Feeds knob codes through the knob channel, starting with a short table of
// extremes and bit patterns, then several random phases with different
// idle and stall mixes. Every returned tempo and period is checked against
// a model of the exponential map, boxcar window and divider, or table values.
// ----------------------------------------------------------------------------
module tempo_knob_smoother_test;
  import tks_pkg::*;

  localparam int AVG_LEN        = 8;
  localparam int RAND_PER_PHASE = 457;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int STALL_LIMIT    = 3000;
  localparam int DIR_ROWS       = 24;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SNK_STALL,
    FLOW_BOTH
  } flow_t;

  typedef struct {
    logic [CODE_W-1:0]   code;
    bit                  typed;
    logic [TEMPO_W-1:0]  tempo;
    logic [PERIOD_W-1:0] period;
  } dir_row_t;

  logic clk;
  logic rst;

  tks_stream_if #(.T(knob_item_t))  knob_ch ();
  tks_stream_if #(.T(tempo_item_t)) tempo_ch ();

  tempo_knob_smoother #(
    .WINDOW(AVG_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .knob(knob_ch),
    .tempo(tempo_ch)
  );

  // model state
  logic [63:0]        ratio_log_q24;
  logic [63:0]        half_roots [1:FRAC_BITS];
  logic [TEMPO_W-1:0] tempo_hist [AVG_LEN];
  logic [31:0]        hist_sum;

  tempo_item_t pending_tempos [$];
  flow_t       flow;
  bit          hold_req;
  int          fails;
  int          quiet_cycles;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{12'd0,    1'b1, 17'd27840, 21'd551724},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b1, 17'd7680,  21'd2000000},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd4095, 1'b0, 17'd0,     21'd0},
    '{12'd0,    1'b0, 17'd0,     21'd0},
    '{12'd1,    1'b0, 17'd0,     21'd0},
    '{12'd2048, 1'b0, 17'd0,     21'd0},
    '{12'd2047, 1'b0, 17'd0,     21'd0},
    '{12'hAAA,  1'b0, 17'd0,     21'd0},
    '{12'h555,  1'b0, 17'd0,     21'd0},
    '{12'd4094, 1'b0, 17'd0,     21'd0},
    '{12'd3000, 1'b0, 17'd0,     21'd0}
  };

  always begin
    #5 clk = ~clk;
  end

  function automatic logic [63:0] sqrt_floor(input logic [63:0] val);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = val;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic build_map_tables();
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] whole;
    logic [63:0] c;
    whole = 0;
    frac  = 0;
    while ((64'(TEMPO_MIN) << (whole + 1)) <= 64'(TEMPO_MAX) && whole < 16) whole++;
    mant = (64'(TEMPO_MAX) << 30) / (64'(TEMPO_MIN) << whole);
    for (int i = 0; i < FRAC_BITS; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    ratio_log_q24 = (whole << FRAC_BITS) | frac;
    c = 64'd1 << 31;
    for (int i = 1; i <= FRAC_BITS; i++) begin
      c = sqrt_floor(c << 30);
      half_roots[i] = c;
    end
  endtask

  function automatic logic [TEMPO_W-1:0] knob_tempo_q8(input logic [CODE_W-1:0] code);
    logic [63:0] expo;
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] prod;
    logic [63:0] t;
    if (TEMPO_MAX <= TEMPO_MIN) return TEMPO_W'(TEMPO_MIN * 256);
    expo  = (ratio_log_q24 * 64'(code)) >> KNOB_BITS;
    ipart = expo >> FRAC_BITS;
    fpart = expo & ((64'd1 << FRAC_BITS) - 1);
    prod  = 64'd1 << 30;
    for (int i = 1; i <= FRAC_BITS; i++) begin
      if (fpart[FRAC_BITS - i]) prod = (prod * half_roots[i]) >> 30;
    end
    if (ipart > 12) ipart = 12;
    t = ((64'(TEMPO_MIN * 256) * prod) << ipart) >> 30;
    if (t > 64'(TEMPO_MAX * 256)) t = 64'(TEMPO_MAX * 256);
    return TEMPO_W'(t);
  endfunction

  task automatic advance_smoother(input logic [CODE_W-1:0] code, output tempo_item_t res);
    logic [TEMPO_W-1:0] fresh;
    logic [63:0]        mean;
    logic [63:0]        per;
    fresh    = knob_tempo_q8(code);
    hist_sum = hist_sum - tempo_hist[AVG_LEN-1];
    for (int i = AVG_LEN - 1; i > 0; i--) tempo_hist[i] = tempo_hist[i-1];
    tempo_hist[0] = fresh;
    hist_sum      = hist_sum + fresh;
    mean          = 64'(hist_sum) / AVG_LEN;
    if (mean == 0) begin
      per = (64'd1 << PERIOD_W) - 1;
    end else begin
      per = 64'd15360000000 / mean;
      if (per > (64'd1 << PERIOD_W) - 1) per = (64'd1 << PERIOD_W) - 1;
    end
    res.tempo_q8  = TEMPO_W'(mean);
    res.period_us = PERIOD_W'(per);
  endtask

  task automatic offer_code(input logic [CODE_W-1:0] code, input bit typed,
                            input tempo_item_t want);
    tempo_item_t res;
    int          idle_pct;
    case (flow)
      FLOW_SRC_IDLE: idle_pct = 48;
      FLOW_BOTH:     idle_pct = 34;
      default:       idle_pct = 0;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      knob_ch.valid <= 1'b0;
      @(posedge clk);
    end
    knob_ch.valid          <= 1'b1;
    knob_ch.data.knob_code <= code;
    @(posedge clk);
    while (!knob_ch.ready) @(posedge clk);
    advance_smoother(code, res);
    if (typed) res = want;
    pending_tempos.push_back(res);
  endtask

  task automatic wait_drained();
    knob_ch.valid <= 1'b0;
    while (pending_tempos.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    tempo_item_t       none;
    logic [CODE_W-1:0] code;
    int                prev;
    int                pick;
    clk                    = 1'b0;
    rst                    = 1'b1;
    knob_ch.valid          = 1'b0;
    knob_ch.data.knob_code = '0;
    flow                   = FLOW_FREE;
    hold_req               = 1'b0;
    fails                  = 0;
    none                   = '0;
    prev                   = 0;
    build_map_tables();
    for (int i = 0; i < AVG_LEN; i++) tempo_hist[i] = TEMPO_W'(TEMPO_DEFAULT * 256);
    hist_sum = AVG_LEN * TEMPO_DEFAULT * 256;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      offer_code(dir_tab[i].code, dir_tab[i].typed, '{dir_tab[i].tempo, dir_tab[i].period});
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      flow = flow_t'(ph);
      if (flow == FLOW_FREE || flow == FLOW_SNK_STALL) hold_req = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          prev = $urandom_range(4095);
        end else if (pick < 75) begin
          case ($urandom_range(3))
            0:       prev = 0;
            1:       prev = 1;
            2:       prev = 4094;
            default: prev = 4095;
          endcase
        end else begin
          prev = prev + $urandom_range(32) - 16;
          if (prev < 0) prev = 0;
          if (prev > 4095) prev = 4095;
        end
        code = CODE_W'(prev);
        offer_code(code, 1'b0, none);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side ready
  initial begin
    int stall_pct;
    tempo_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        tempo_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (flow)
          FLOW_SNK_STALL: stall_pct = 48;
          FLOW_BOTH:      stall_pct = 34;
          default:        stall_pct = 0;
        endcase
        tempo_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    tempo_item_t got;
    tempo_item_t want;
    if (!rst) begin
      if (tempo_ch.valid && tempo_ch.ready) begin
        got = tempo_ch.data;
        if (pending_tempos.size() == 0) begin
          $error("unexpected transaction: tempo_q8 %0d period_us %0d",
                 got.tempo_q8, got.period_us);
          fails++;
        end else begin
          want = pending_tempos.pop_front();
          if (got.tempo_q8 !== want.tempo_q8) begin
            $error("tempo_q8 expected %0d actual %0d", want.tempo_q8, got.tempo_q8);
            fails++;
          end
          if (got.period_us !== want.period_us) begin
            $error("period_us expected %0d actual %0d", want.period_us, got.period_us);
            fails++;
          end
        end
      end
      if ((tempo_ch.valid && tempo_ch.ready) || (knob_ch.valid && knob_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule
